### hw/rtl/opc_pkg.sv
// ----------------------------------------------------------------------------
// OBD-II PID poll client package
// Shared types, constants and register map of the speed polling client.
// ----------------------------------------------------------------------------
package opc_pkg;

  localparam int TIMER_BITS = 16;
  localparam int CFG_TIMER_BITS = 16;
  localparam int CMP_BITS = (TIMER_BITS > CFG_TIMER_BITS) ? TIMER_BITS : CFG_TIMER_BITS;

  localparam int ADDR_BITS = 5;
  localparam int DATA_BITS = 32;
  localparam int IN_DATA_BITS = 56;
  localparam int OUT_DATA_BITS = 24;

  localparam logic [15:0] SAMPLE_INTERVAL_RST = 16'd5000;
  localparam logic [15:0] RESPONSE_TIMEOUT_RST = 16'd10000;
  localparam logic [3:0]  MAX_SEND_ERRORS_RST = 4'd3;
  localparam logic [7:0]  SPEED_PID_RST = 8'd13;
  localparam logic [7:0]  RESPONSE_MODE_RST = 8'h01;

  localparam logic [28:0] BCAST_ID = 29'h7DF;
  localparam logic [7:0]  TOOL_ADDR = 8'hF1;
  localparam logic [12:0] PHYS_PREFIX = 13'h18DA;
  localparam logic [12:0] FUNC_PREFIX = 13'h18DB;

  typedef enum logic [2:0] {
    REG_SAMPLE_INTERVAL  = 3'd0,
    REG_RESPONSE_TIMEOUT = 3'd1,
    REG_MAX_SEND_ERRORS  = 3'd2,
    REG_SPEED_PID        = 3'd3,
    REG_RESPONSE_MODE    = 3'd4
  } reg_index_t;

  typedef enum logic [1:0] {
    CMD_TICK  = 2'd0,
    CMD_FRAME = 2'd1,
    CMD_READ  = 2'd2
  } cmd_t;

  typedef enum logic [1:0] {
    PH_IDLE = 2'd0,
    PH_WAIT = 2'd1,
    PH_RECV = 2'd2
  } phase_t;

  typedef struct packed {
    logic [15:0] sample_interval_ms;
    logic [15:0] response_timeout_ms;
    logic [3:0]  max_send_errors;
    logic [7:0]  speed_pid;
    logic [7:0]  response_mode;
  } opc_cfg_t;

  typedef struct packed {
    logic [1:0]  cmd;
    logic [28:0] frame_id;
    logic        frame_extended;
    logic [7:0]  frame_mode;
    logic [7:0]  frame_pid;
    logic [7:0]  frame_value;
    logic        send_ok;
  } opc_item_t;

  typedef struct packed {
    logic [1:0] client_phase;
    logic       speed_valid;
    logic [7:0] speed_kph;
    logic       timed_out;
    logic       controller_reset;
    logic [7:0] request_pid;
    logic       send_request;
  } opc_result_t;

endpackage

### hw/rtl/opc_cfg.sv
// ----------------------------------------------------------------------------
// OBD-II PID poll client configuration registers
// APB-style register file holding the intervals, limits and match bytes.
// ----------------------------------------------------------------------------
module opc_cfg (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [opc_pkg::ADDR_BITS-1:0]   paddr,
  input  logic [opc_pkg::DATA_BITS-1:0]   pwdata,
  output logic [opc_pkg::DATA_BITS-1:0]   prdata,
  output logic                            pready,
  output opc_pkg::opc_cfg_t               cfg
);
  import opc_pkg::*;

  logic       wr_en;
  reg_index_t idx;

  assign pready = 1'b1;
  assign wr_en = psel & penable & pwrite;
  assign idx = reg_index_t'(paddr[ADDR_BITS-1:2]);

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.sample_interval_ms <= SAMPLE_INTERVAL_RST;
      cfg.response_timeout_ms <= RESPONSE_TIMEOUT_RST;
      cfg.max_send_errors <= MAX_SEND_ERRORS_RST;
      cfg.speed_pid <= SPEED_PID_RST;
      cfg.response_mode <= RESPONSE_MODE_RST;
    end else if (wr_en) begin
      case (idx)
        REG_SAMPLE_INTERVAL:  cfg.sample_interval_ms <= pwdata[15:0];
        REG_RESPONSE_TIMEOUT: cfg.response_timeout_ms <= pwdata[15:0];
        REG_MAX_SEND_ERRORS:  cfg.max_send_errors <= pwdata[3:0];
        REG_SPEED_PID:        cfg.speed_pid <= pwdata[7:0];
        REG_RESPONSE_MODE:    cfg.response_mode <= pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_SAMPLE_INTERVAL:  prdata = DATA_BITS'(cfg.sample_interval_ms);
      REG_RESPONSE_TIMEOUT: prdata = DATA_BITS'(cfg.response_timeout_ms);
      REG_MAX_SEND_ERRORS:  prdata = DATA_BITS'(cfg.max_send_errors);
      REG_SPEED_PID:        prdata = DATA_BITS'(cfg.speed_pid);
      REG_RESPONSE_MODE:    prdata = DATA_BITS'(cfg.response_mode);
      default:              prdata = '0;
    endcase
  end

endmodule

### hw/rtl/opc_core.sv
// ----------------------------------------------------------------------------
// OBD-II PID poll client core
// Client state machine, elapsed timers and speed latch, updated once per item.
// ----------------------------------------------------------------------------
module opc_core (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  accept,
  input  opc_pkg::opc_item_t    item,
  input  opc_pkg::opc_cfg_t     cfg,
  output opc_pkg::opc_result_t  result
);
  import opc_pkg::*;

  phase_t                phase, phase_next;
  logic [TIMER_BITS-1:0] since_sample, since_sample_next;
  logic [TIMER_BITS-1:0] since_request, since_request_next;
  logic [3:0]            fail_count, fail_count_next;
  logic [7:0]            speed_store, speed_store_next;
  logic                  speed_ok, speed_ok_next;
  logic [7:0]            held_mode, held_mode_next;
  logic [7:0]            held_pid, held_pid_next;
  logic [7:0]            held_value, held_value_next;
  logic [TIMER_BITS-1:0] sample_inc, request_inc;
  logic [3:0]            fail_inc;
  logic                  routed;

  assign sample_inc = (since_sample == '1) ? since_sample : since_sample + TIMER_BITS'(1);
  assign request_inc = (since_request == '1) ? since_request : since_request + TIMER_BITS'(1);
  assign fail_inc = fail_count + 4'd1;

  always_comb begin
    if (item.frame_extended && (item.frame_id[28:16] == PHYS_PREFIX ||
        item.frame_id[28:16] == FUNC_PREFIX)) begin
      routed = (item.frame_id[15:8] == TOOL_ADDR);
    end else begin
      routed = (item.frame_id != BCAST_ID);
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase <= PH_IDLE;
      since_sample <= '0;
      since_request <= '0;
      fail_count <= '0;
      speed_store <= '0;
      speed_ok <= 1'b0;
      held_mode <= '0;
      held_pid <= '0;
      held_value <= '0;
    end else if (accept) begin
      phase <= phase_next;
      since_sample <= since_sample_next;
      since_request <= since_request_next;
      fail_count <= fail_count_next;
      speed_store <= speed_store_next;
      speed_ok <= speed_ok_next;
      held_mode <= held_mode_next;
      held_pid <= held_pid_next;
      held_value <= held_value_next;
    end
  end

  always_comb begin
    phase_next = phase;
    since_sample_next = since_sample;
    since_request_next = since_request;
    fail_count_next = fail_count;
    speed_store_next = speed_store;
    speed_ok_next = speed_ok;
    held_mode_next = held_mode;
    held_pid_next = held_pid;
    held_value_next = held_value;
    result = '0;
    case (cmd_t'(item.cmd))
      CMD_TICK: begin
        since_sample_next = sample_inc;
        since_request_next = request_inc;
        case (phase)
          PH_IDLE: begin
            if (CMP_BITS'(sample_inc) >= CMP_BITS'(cfg.sample_interval_ms)) begin
              speed_store_next = '0;
              speed_ok_next = 1'b0;
              result.send_request = 1'b1;
              result.request_pid = cfg.speed_pid;
              since_sample_next = '0;
              if (!item.send_ok) begin
                if (fail_inc >= cfg.max_send_errors) begin
                  result.controller_reset = 1'b1;
                  fail_count_next = '0;
                end else begin
                  fail_count_next = fail_inc;
                end
              end else begin
                fail_count_next = '0;
                since_request_next = '0;
                phase_next = PH_WAIT;
              end
            end
          end
          PH_WAIT: begin
            if (CMP_BITS'(request_inc) >= CMP_BITS'(cfg.response_timeout_ms)) begin
              result.timed_out = 1'b1;
              phase_next = PH_IDLE;
            end
          end
          PH_RECV: begin
            if (held_mode == cfg.response_mode && held_pid == cfg.speed_pid) begin
              speed_ok_next = 1'b1;
              speed_store_next = held_value;
            end
            phase_next = PH_IDLE;
          end
          default: phase_next = PH_IDLE;
        endcase
      end
      CMD_FRAME: begin
        if (routed) begin
          held_mode_next = item.frame_mode;
          held_pid_next = item.frame_pid;
          held_value_next = item.frame_value;
          phase_next = PH_RECV;
        end
      end
      CMD_READ: begin
        result.speed_valid = speed_ok;
        speed_ok_next = 1'b0;
      end
      default: ;
    endcase
    result.speed_kph = speed_store_next;
    result.client_phase = phase_next;
  end

endmodule

### hw/rtl/obd_pid_poll_client.sv
// Results: a result is registered and appears on the master side in the cycle after its item is accepted.
// Throughput: one item per cycle; a new item is taken in the cycle the waiting result
// is taken, and the slave side stalls while the master side holds a result back.
// Reset: synchronous, active high; state, timers and config registers take their reset values.
// ----------------------------------------------------------------------------
// OBD-II PID poll client
// Stream-facing top level: configuration port, client core and result register.
// ----------------------------------------------------------------------------
module obd_pid_poll_client (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              s_tvalid,
  output logic                              s_tready,
  // frame_id, frame_extended, frame_mode, frame_pid, frame_value, send_ok, zero pad
  input  logic [opc_pkg::IN_DATA_BITS-1:0]  s_tdata,
  // cmd
  input  logic [1:0]                        s_tuser,
  output logic                              m_tvalid,
  input  logic                              m_tready,
  // send_request, request_pid, controller_reset, timed_out, speed_kph,
  // speed_valid, client_phase, zero pad
  output logic [opc_pkg::OUT_DATA_BITS-1:0] m_tdata,
  input  logic                              psel,
  input  logic                              penable,
  input  logic                              pwrite,
  input  logic [opc_pkg::ADDR_BITS-1:0]     paddr,
  input  logic [opc_pkg::DATA_BITS-1:0]     pwdata,
  output logic [opc_pkg::DATA_BITS-1:0]     prdata,
  output logic                              pready
);
  import opc_pkg::*;

  opc_cfg_t    cfg;
  opc_item_t   item;
  opc_result_t result;
  logic        accept;

  assign s_tready = !m_tvalid || m_tready;
  assign accept = s_tvalid && s_tready;

  assign item.cmd = s_tuser;
  assign item.frame_id = s_tdata[28:0];
  assign item.frame_extended = s_tdata[29];
  assign item.frame_mode = s_tdata[37:30];
  assign item.frame_pid = s_tdata[45:38];
  assign item.frame_value = s_tdata[53:46];
  assign item.send_ok = s_tdata[54];

  opc_cfg u_cfg (
    .clk     (clk),
    .rst     (rst),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  opc_core u_core (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .item   (item),
    .cfg    (cfg),
    .result (result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s_tready) begin
      m_tvalid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      m_tdata <= OUT_DATA_BITS'(result);
    end
  end

endmodule

### hw/rtl/opc_checker.sv
// ----------------------------------------------------------------------------
// OBD-II PID poll client checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
module opc_checker (
  input logic                              clk,
  input logic                              rst,
  input logic                              s_tvalid,
  input logic                              s_tready,
  input logic                              m_tvalid,
  input logic                              m_tready,
  input logic [opc_pkg::OUT_DATA_BITS-1:0] m_tdata
);

  a_hold: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
    else $error("Stalled result changed or was dropped.");

  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready |=> m_tvalid)
    else $error("Accepted item produced no result.");

  a_pid_only_on_send: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0 && !m_tdata[9])
    else $error("Request PID or controller reset without a send.");

  a_timeout_idle: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tdata[10] |-> !m_tdata[0] && m_tdata[21:20] == 2'd0)
    else $error("Timeout result not idle or carries a send.");

endmodule

bind obd_pid_poll_client opc_checker u_opc_checker (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);
